// ----- hw/rtl/cstc_pkg.sv -----
// cstc_pkg: shared types, constants and sequencing functions for the
// channel sediment transport capacity block; no dependencies
`timescale 1ns / 1ps

package cstc_pkg;

  localparam int MAX_SOLIDS     = 4;
  localparam int NUM_CLASS_REGS = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;

  localparam int MUL_W      = 64;
  localparam int MUL_STEPS  = 4;
  localparam int DVD_W      = 100;
  localparam int DSR_W      = 50;
  localparam int QUO_W      = 48;
  localparam int DIV_STEPS  = 100;
  localparam int SQX_W      = 56;
  localparam int SQRT_STEPS = 28;
  localparam int SQR_W      = 28;

  localparam logic [CFG_IDX_W-1:0] REG_SOLID_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_FIRST = 3'd1;

  localparam logic [15:0] ONE_Q12  = 16'd4096;
  localparam logic [35:0] SUM_MAX  = 36'hF_FFFF_FFFF;
  localparam logic [47:0] CAP_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  // reciprocal of 981 in Q64, rounded up; exact floor for products below 2^54
  localparam logic [63:0] K_GRAV_RECIP = 64'((128'd1 << 64) / 128'd981 + 128'd1);
  localparam logic [15:0] K_HUNDRED = 16'd100;
  localparam logic [15:0] K_CW     = 16'd50000;
  localparam logic [15:0] K_CAP    = 16'd15625;

  typedef struct packed {
    logic        mode;
    logic [31:0] outflow;
    logic [23:0] depth;
    logic [23:0] bottom_width;
    logic [23:0] bank_height;
    logic [23:0] side_slope;
    logic [23:0] top_width;
    logic signed [23:0] friction_slope;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  solid_index;
    logic [47:0] capacity;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACC, OP_LOAD,
    OP_SS2, OP_ROOT, OP_TRAP, OP_AREA1, OP_AREA2, OP_WP, OP_RH, OP_VEL,
    OP_RSM, OP_RS100, OP_RSDIV, OP_RS, OP_A20, OP_B20, OP_C,
    OP_GM2, OP_GMD, OP_NCW, OP_CW, OP_GCW, OP_DEN, OP_S15, OP_NCAP, OP_CAP
  } op_t;

  typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV, U_SQRT} unit_t;

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_CLASS, ST_EMIT} state_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [1:0] cls;
    logic       emit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic       skip;
    logic [2:0] n;
  } status_t;

  function automatic unit_t op_unit(op_t op);
    unit_t u;
    u = U_NONE;
    case (op) inside
      OP_ROOT, OP_RS: u = U_SQRT;
      OP_RH, OP_VEL, OP_CW, OP_CAP: u = U_DIV;
      OP_SS2, OP_TRAP, OP_AREA1, OP_AREA2, OP_WP, OP_RSM, OP_RS100, OP_RSDIV,
      OP_A20, OP_B20, OP_C, OP_GM2, OP_GMD, OP_NCW, OP_GCW, OP_DEN, OP_S15,
      OP_NCAP: u = U_MUL;
      default: u = U_NONE;
    endcase
    return u;
  endfunction

  function automatic op_t op_next(op_t op);
    op_t n;
    case (op)
      OP_SS2:   n = OP_ROOT;
      OP_ROOT:  n = OP_TRAP;
      OP_TRAP:  n = OP_AREA1;
      OP_AREA1: n = OP_AREA2;
      OP_AREA2: n = OP_WP;
      OP_WP:    n = OP_RH;
      OP_RH:    n = OP_VEL;
      OP_RSM:   n = OP_RS100;
      OP_RS100: n = OP_RSDIV;
      OP_RSDIV: n = OP_RS;
      OP_RS:    n = OP_A20;
      OP_A20:   n = OP_B20;
      OP_B20:   n = OP_C;
      OP_C:     n = OP_GM2;
      OP_GM2:   n = OP_GMD;
      OP_GMD:   n = OP_NCW;
      OP_NCW:   n = OP_CW;
      OP_CW:    n = OP_GCW;
      OP_GCW:   n = OP_DEN;
      OP_DEN:   n = OP_S15;
      OP_S15:   n = OP_NCAP;
      OP_NCAP:  n = OP_CAP;
      default:  n = OP_NONE;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/channel_sediment_transport_capacity.sv -----
// accumulate item: added to the outflow sum while idle; node item with a nonzero class count:
// geometry first (two divisions, a root, multiplies), then each evaluated class
// in turn, with its two divisions on the shared divider, or no unit work for a
// class that gives zero; output stalls hold back each result;
// items are taken only between nodes, a node with no classes stays idle
// rst is synchronous: count 1, classes 0, outflow sum 0, no result pending
`timescale 1ns / 1ps

module channel_sediment_transport_capacity (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cstc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cstc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [cstc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cstc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cstc_pkg::cmd_t    cmd;
  cstc_pkg::status_t status;

  cstc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cstc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/cstc_mul.sv -----
// cstc_mul: multi-cycle 64x64 multiplier, one 16-bit digit of b per cycle
// depends on cstc_pkg
`timescale 1ns / 1ps

module cstc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cstc_pkg::MUL_W-1:0]  a_in,
  input  logic [cstc_pkg::MUL_W-1:0]  b_in,
  output logic                        done,
  output logic [2*cstc_pkg::MUL_W-1:0] prod
);

  localparam int W = cstc_pkg::MUL_W;

  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [2*W-1:0] acc;
  logic [1:0]     cnt;
  logic           busy;
  logic [W+15:0]  pp;
  logic [2*W+15:0] sum;

  assign pp   = {16'b0, a} * {{W{1'b0}}, b[15:0]};
  assign sum  = {16'b0, acc} + {pp, {W{1'b0}}};
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'(cstc_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= a_in;
      b   <= b_in;
      acc <= '0;
    end else if (busy) begin
      acc <= sum[2*W+15:16];
      b   <= b >> 16;
    end
  end

endmodule

// ----- hw/rtl/cstc_divsqrt.sv -----
// cstc_divsqrt: iterative restoring divider with sticky quotient overflow
// and bit-pair integer square root; depends on cstc_pkg
`timescale 1ns / 1ps

module cstc_divsqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start_div,
  input  logic                        start_sqrt,
  input  logic [cstc_pkg::DVD_W-1:0]  dvd_in,
  input  logic [cstc_pkg::DSR_W-1:0]  dsr_in,
  input  logic [cstc_pkg::SQX_W-1:0]  sx_in,
  output logic                        done,
  output logic [cstc_pkg::QUO_W-1:0]  quo,
  output logic                        ovf,
  output logic [cstc_pkg::SQR_W-1:0]  root
);

  localparam int DW = cstc_pkg::DVD_W;
  localparam int SW = cstc_pkg::DSR_W;
  localparam int QW = cstc_pkg::QUO_W;
  localparam int XW = cstc_pkg::SQX_W;

  logic          busy;
  logic          is_sq;
  logic [6:0]    cnt;
  logic [DW-1:0] dvd;
  logic [SW-1:0] dsr;
  logic [SW-1:0] rem;
  logic [QW-1:0] q;
  logic [SW:0]   r2;
  logic [SW:0]   diff;
  logic          ge;
  logic [XW-1:0] x;
  logic [XW-1:0] r;
  logic [XW-1:0] bitm;
  logic [XW-1:0] trial;
  logic          sge;

  assign r2    = {rem, dvd[DW-1]};
  assign ge    = r2 >= {1'b0, dsr};
  assign diff  = r2 - {1'b0, dsr};
  assign trial = r + bitm;
  assign sge   = x >= trial;
  assign quo   = q;
  assign root  = r[cstc_pkg::SQR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start_div || start_sqrt) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if ((!is_sq && cnt == 7'(cstc_pkg::DIV_STEPS - 1)) ||
            (is_sq && cnt == 7'(cstc_pkg::SQRT_STEPS - 1))) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      is_sq <= 1'b0;
      dvd   <= dvd_in;
      dsr   <= dsr_in;
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
    end else if (start_sqrt) begin
      is_sq <= 1'b1;
      x     <= sx_in;
      r     <= '0;
      bitm  <= XW'(1) << (XW - 2);
    end else if (busy) begin
      if (is_sq) begin
        if (sge) begin
          x <= x - trial;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
      end else begin
        dvd <= dvd << 1;
        rem <= ge ? diff[SW-1:0] : r2[SW-1:0];
        q   <= {q[QW-2:0], ge};
        ovf <= ovf | q[QW-1];
      end
    end
  end

endmodule

// ----- hw/rtl/cstc_dp.sv -----
// cstc_dp: datapath with configuration, outflow sum, node and class
// registers, shared multiplier and divider/root unit; depends on cstc_pkg
`timescale 1ns / 1ps

module cstc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  cstc_pkg::in_item_t               in_data,
  input  logic                             cfg_we,
  input  logic [cstc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cstc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cstc_pkg::cmd_t                   cmd,
  output cstc_pkg::status_t                status,
  output cstc_pkg::out_item_t              out_data
);

  localparam int CFG_IDX_LOCAL = cstc_pkg::CFG_IDX_W;

  logic [2:0]  count;
  logic [47:0] cls [cstc_pkg::NUM_CLASS_REGS];
  logic [35:0] outflow_sum;
  logic [36:0] acc_sum;
  logic [CFG_IDX_LOCAL-1:0] cls_wr;

  // node registers
  logic [23:0] hh, ov, bw, ss, tw, sf;
  logic [35:0] node_sum;
  logic [24:0] root;
  logic [32:0] trap;
  logic [41:0] area;
  logic [35:0] wp;
  logic [23:0] rh;
  logic [31:0] vel;
  logic [55:0] tmp;
  // class registers
  logic [21:0] rs;
  logic [39:0] a20;
  logic [43:0] b20;
  logic [59:0] c;
  logic [99:0] num;
  logic [32:0] cw;
  logic [48:0] gcw;
  logic [47:0] den;
  logic [49:0] s15;
  logic [47:0] cap;

  cstc_pkg::op_t cur_op;

  logic [47:0] sel;
  logic [15:0] g, d, gm1;
  logic [19:0] vc;

  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         mul_start, mul_done;
  logic [99:0]  dvd;
  logic [49:0]  dsr;
  logic [55:0]  sx;
  logic         div_start, sqrt_start, ds_done;
  logic [47:0]  quo;
  logic         ovf;
  logic [27:0]  sq;
  cstc_pkg::unit_t unit;

  assign sel = cls[cmd.cls];
  assign g   = sel[15:0];
  assign d   = sel[31:16];
  assign vc  = {sel[47:32], 4'b0};
  assign gm1 = g - cstc_pkg::ONE_Q12;

  assign status.n = (count > 3'(cstc_pkg::MAX_SOLIDS)) ? 3'(cstc_pkg::MAX_SOLIDS) : count;
  assign status.skip = (area == '0) || (g <= cstc_pkg::ONE_Q12) || (d == '0) ||
                       (vel <= {12'b0, vc});
  assign status.done = mul_done | ds_done;

  assign acc_sum = {1'b0, outflow_sum} + {5'b0, in_data.outflow};
  assign cls_wr  = cfg_index - cstc_pkg::REG_CLASS_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= 3'd1;
      outflow_sum <= '0;
      for (int i = 0; i < cstc_pkg::NUM_CLASS_REGS; i++) cls[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cstc_pkg::REG_SOLID_COUNT) begin
          count <= cfg_data[2:0];
        end else if (cfg_index >= cstc_pkg::REG_CLASS_FIRST &&
                     cfg_index < cstc_pkg::REG_CLASS_FIRST +
                                 3'(cstc_pkg::NUM_CLASS_REGS)) begin
          cls[cls_wr[1:0]] <= cfg_data;
        end
      end
      if (cmd.start && cmd.op == cstc_pkg::OP_ACC) begin
        outflow_sum <= acc_sum[36] ? cstc_pkg::SUM_MAX : acc_sum[35:0];
      end else if (cmd.start && cmd.op == cstc_pkg::OP_LOAD) begin
        outflow_sum <= '0;
      end
    end
  end

  // operand selection for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dvd   = '0;
    dsr   = '0;
    sx    = tmp;
    case (cmd.op)
      cstc_pkg::OP_SS2:   begin mul_a = 64'(ss);   mul_b = 64'(ss); end
      cstc_pkg::OP_TRAP:  begin mul_a = 64'(ss);   mul_b = 64'(hh); end
      cstc_pkg::OP_AREA1: begin mul_a = 64'(trap); mul_b = 64'(hh); end
      cstc_pkg::OP_AREA2: begin mul_a = 64'(ov);   mul_b = 64'(tw); end
      cstc_pkg::OP_WP:    begin mul_a = 64'(hh);   mul_b = 64'(root); end
      cstc_pkg::OP_RH:    begin dvd = {42'b0, area, 16'b0}; dsr = 50'(wp); end
      cstc_pkg::OP_VEL:   begin dvd = {48'b0, node_sum, 16'b0}; dsr = 50'(area); end
      cstc_pkg::OP_RSM:   begin mul_a = 64'(rh);   mul_b = 64'(sf); end
      cstc_pkg::OP_RS100: begin mul_a = 64'(tmp);  mul_b = 64'(cstc_pkg::K_HUNDRED); end
      cstc_pkg::OP_RSDIV: begin mul_a = 64'(tmp);  mul_b = cstc_pkg::K_GRAV_RECIP; end
      cstc_pkg::OP_A20:   begin mul_a = 64'(vel - {12'b0, vc}); mul_b = 64'(sf); end
      cstc_pkg::OP_B20:   begin mul_a = 64'(a20);  mul_b = 64'(rs); end
      cstc_pkg::OP_C:     begin mul_a = 64'(b20);  mul_b = 64'(g); end
      cstc_pkg::OP_GM2:   begin mul_a = 64'(gm1);  mul_b = 64'(gm1); end
      cstc_pkg::OP_GMD:   begin mul_a = 64'(tmp);  mul_b = 64'(d); end
      cstc_pkg::OP_NCW:   begin mul_a = 64'(c);    mul_b = 64'(cstc_pkg::K_CW); end
      cstc_pkg::OP_CW:    begin dvd = num; dsr = 50'(tmp[47:0]); end
      cstc_pkg::OP_GCW:   begin mul_a = 64'(g);    mul_b = 64'(cw); end
      cstc_pkg::OP_DEN:   begin mul_a = 64'(gm1);  mul_b = 64'(cw); end
      cstc_pkg::OP_S15:   begin mul_a = 64'(node_sum); mul_b = 64'(cstc_pkg::K_CAP); end
      cstc_pkg::OP_NCAP:  begin mul_a = 64'(s15);  mul_b = 64'(gcw); end
      cstc_pkg::OP_CAP:   begin dvd = num; dsr = {den, 2'b0}; end
      default: ;
    endcase
  end

  assign unit       = cstc_pkg::op_unit(cmd.op);
  assign mul_start  = cmd.start && unit == cstc_pkg::U_MUL;
  assign div_start  = cmd.start && unit == cstc_pkg::U_DIV;
  assign sqrt_start = cmd.start && unit == cstc_pkg::U_SQRT;

  cstc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  cstc_divsqrt u_divsqrt (
    .clk        (clk),
    .rst        (rst),
    .start_div  (div_start),
    .start_sqrt (sqrt_start),
    .dvd_in     (dvd),
    .dsr_in     (dsr),
    .sx_in      (sx),
    .done       (ds_done),
    .quo        (quo),
    .ovf        (ovf),
    .root       (sq)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) cur_op <= cmd.op;
    if (cmd.start && cmd.op == cstc_pkg::OP_LOAD) begin
      hh <= (in_data.depth <= in_data.bank_height) ? in_data.depth : in_data.bank_height;
      ov <= (in_data.depth > in_data.bank_height) ?
            in_data.depth - in_data.bank_height : '0;
      bw <= in_data.bottom_width;
      ss <= in_data.side_slope;
      tw <= in_data.top_width;
      sf <= in_data.friction_slope[23] ? 24'd0 - in_data.friction_slope :
            in_data.friction_slope;
      node_sum <= outflow_sum;
    end
    if (status.done) begin
      case (cur_op)
        cstc_pkg::OP_SS2:   tmp  <= 56'(prod[47:0]) + 56'(cstc_pkg::ONE_Q32);
        cstc_pkg::OP_ROOT:  root <= sq[24:0];
        cstc_pkg::OP_TRAP:  trap <= 33'(bw) + 33'(prod[47:16]);
        cstc_pkg::OP_AREA1: area <= 42'(prod[56:16]);
        cstc_pkg::OP_AREA2: area <= area + 42'(prod[47:16]);
        cstc_pkg::OP_WP:    wp   <= 36'(bw) + 36'(prod[48:15]) + 36'({ov, 1'b0});
        cstc_pkg::OP_RH:    rh   <= (ovf || quo[47:24] != '0) ? 24'hFF_FFFF : quo[23:0];
        cstc_pkg::OP_VEL:   vel  <= (ovf || quo[47:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
        cstc_pkg::OP_RSM:   tmp  <= 56'(prod[47:0]);
        cstc_pkg::OP_RS100: tmp  <= 56'(prod[53:0]);
        cstc_pkg::OP_RSDIV: tmp  <= 56'(prod[127:64]);
        cstc_pkg::OP_RS:    rs   <= sq[21:0];
        cstc_pkg::OP_A20:   a20  <= prod[55:16];
        cstc_pkg::OP_B20:   b20  <= prod[61:18];
        cstc_pkg::OP_C:     c    <= prod[59:0];
        cstc_pkg::OP_GM2:   tmp  <= 56'(prod[31:0]);
        cstc_pkg::OP_GMD:   tmp  <= 56'(prod[47:0]);
        cstc_pkg::OP_NCW:   num  <= {prod[75:0], 24'b0};
        cstc_pkg::OP_CW:    cw   <= (ovf || quo > 48'(cstc_pkg::ONE_Q32)) ?
                                    cstc_pkg::ONE_Q32 : quo[32:0];
        cstc_pkg::OP_GCW:   gcw  <= prod[48:0];
        cstc_pkg::OP_DEN:   den  <= {g, 32'b0} - prod[47:0];
        cstc_pkg::OP_S15:   s15  <= prod[49:0];
        cstc_pkg::OP_NCAP:  num  <= prod[99:0];
        cstc_pkg::OP_CAP:   cap  <= ovf ? cstc_pkg::CAP_MAX : quo;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_data.solid_index <= cmd.cls;
      out_data.capacity    <= status.skip ? '0 : cap;
      out_data.last        <= cmd.last;
    end
  end

endmodule

// ----- hw/rtl/cstc_ctrl.sv -----
// cstc_ctrl: sequencer for node and class operations and output transfer
// control; depends on cstc_pkg
`timescale 1ns / 1ps

module cstc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  cstc_pkg::status_t status,
  output cstc_pkg::cmd_t    cmd
);

  cstc_pkg::state_t state, state_next;
  cstc_pkg::op_t    op, op_next;
  logic [1:0]       k, k_next;
  logic             is_last;

  assign is_last = ({1'b0, k} + 3'd1) == status.n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cstc_pkg::ST_IDLE;
      op        <= cstc_pkg::OP_NONE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      k     <= k_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    k_next     = k;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = cstc_pkg::OP_NONE;
    cmd.cls    = k;
    case (state)
      cstc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cmd.op    = in_mode ? cstc_pkg::OP_LOAD : cstc_pkg::OP_ACC;
          if (in_mode) begin
            k_next = '0;
            if (status.n != '0) begin
              op_next    = cstc_pkg::OP_SS2;
              state_next = cstc_pkg::ST_ISSUE;
            end
          end
        end
      end
      cstc_pkg::ST_ISSUE: begin
        cmd.start  = 1'b1;
        cmd.op     = op;
        state_next = cstc_pkg::ST_WAIT;
      end
      cstc_pkg::ST_WAIT: begin
        if (status.done) begin
          if (op == cstc_pkg::OP_VEL) begin
            state_next = cstc_pkg::ST_CLASS;
          end else if (op == cstc_pkg::OP_CAP) begin
            state_next = cstc_pkg::ST_EMIT;
          end else begin
            op_next    = cstc_pkg::op_next(op);
            state_next = cstc_pkg::ST_ISSUE;
          end
        end
      end
      cstc_pkg::ST_CLASS: begin
        if (status.skip) begin
          state_next = cstc_pkg::ST_EMIT;
        end else begin
          op_next    = cstc_pkg::OP_RSM;
          state_next = cstc_pkg::ST_ISSUE;
        end
      end
      cstc_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          cmd.last = is_last;
          if (is_last) begin
            state_next = cstc_pkg::ST_IDLE;
          end else begin
            k_next     = k + 2'd1;
            state_next = cstc_pkg::ST_CLASS;
          end
        end
      end
      default: state_next = cstc_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result written over an untaken result");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == cstc_pkg::ST_WAIT)
    else $error("unit completion outside wait state");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == cstc_pkg::ST_IDLE && out_valid))
    else $error("last result did not return to idle");
  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == cstc_pkg::ST_WAIT && !status.done) |=> !cmd.start ||
      state == cstc_pkg::ST_IDLE || state == cstc_pkg::ST_ISSUE)
    else $error("unit started while busy");
`endif

endmodule
